### src/tls_pkg.sv
// Package: shared types and constants of the temperature log statistics block.
`timescale 1ns / 1ps
package tls_pkg;

    localparam int SLOT_W  = 7;
    localparam int TEMP_W  = 8;
    localparam int WRAP_W  = 8;
    localparam int IDX_W   = 16;
    localparam int HUND_W  = 7;
    localparam int SUM_W   = 24;
    localparam int MAG_W   = 23;
    localparam int STEP_W  = 5;
    localparam int Q_DEPTH = 2;
    localparam int FRAC_STEPS = 7;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic [IDX_W-1:0] COUNT_MAX = '1;
    localparam logic [6:0]       HUNDRED   = 7'd100;

    typedef logic        [SLOT_W-1:0] slot_t;
    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic        [WRAP_W-1:0] wrap_t;
    typedef logic        [IDX_W-1:0]  idx_t;
    typedef logic        [HUND_W-1:0] hund_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic        [MAG_W-1:0]  mag_t;
    typedef logic        [STEP_W-1:0] step_t;

    // One classified item on its way from the front end to the divider.
    typedef struct packed {
        slot_t slot;
        wrap_t wrap_total;
        idx_t  sample_index;
        temp_t max_temp;
        idx_t  max_index;
        temp_t min_temp;
        idx_t  min_index;
        logic  new_max;
        logic  new_min;
        temp_t log_value;
        logic  mean_neg;
        mag_t  mean_mag;
        idx_t  mean_count;
    } tls_job_t;

    typedef struct packed {
        slot_t slot;
        wrap_t wrap_total;
        idx_t  sample_index;
        temp_t mean_whole;
        hund_t mean_hundredths;
        temp_t max_temp;
        idx_t  max_index;
        temp_t min_temp;
        idx_t  min_index;
        logic  new_max;
        logic  new_min;
        temp_t log_value;
    } tls_result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tls_q_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV1,
        BK_MUL,
        BK_DIV2,
        BK_DONE
    } tls_back_state_t;

endpackage

### src/tls_if.sv
// Interfaces: request and result channels of the temperature log statistics block.
`timescale 1ns / 1ps
interface tls_req_if;
    import tls_pkg::*;
    logic  valid;
    logic  ready;
    logic  kind;
    temp_t temperature;
    slot_t read_slot;
    modport source (output valid, kind, temperature, read_slot, input ready);
    modport sink   (input valid, kind, temperature, read_slot, output ready);
endinterface

interface tls_rsp_if;
    import tls_pkg::*;
    logic  valid;
    logic  ready;
    slot_t slot;
    wrap_t wrap_total;
    idx_t  sample_index;
    temp_t mean_whole;
    hund_t mean_hundredths;
    temp_t max_temp;
    idx_t  max_index;
    temp_t min_temp;
    idx_t  min_index;
    logic  new_max;
    logic  new_min;
    temp_t log_value;
    modport source (output valid, slot, wrap_total, sample_index, mean_whole,
                    mean_hundredths, max_temp, max_index, min_temp, min_index,
                    new_max, new_min, log_value, input ready);
    modport sink   (input valid, slot, wrap_total, sample_index, mean_whole,
                    mean_hundredths, max_temp, max_index, min_temp, min_index,
                    new_max, new_min, log_value, output ready);
endinterface

### src/tls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 99
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### src/tls_front.sv
// Front end: accepts requests, keeps the ring log and running statistics, queues jobs.
`timescale 1ns / 1ps
module tls_front #(
    parameter int LOG_DEPTH = 99
) (
    input  logic                   clk,
    input  logic                   rst_n,
    tls_req_if.sink                req,
    input  tls_pkg::tls_q_status_t q_status,
    output logic                   push,
    output tls_pkg::tls_job_t      push_job
);
    import tls_pkg::*;

    localparam int AW = $clog2(LOG_DEPTH);

    logic                 valid_reg [LOG_DEPTH];
    slot_t                write_slot_reg, write_slot_next;
    wrap_t                wrap_reg, wrap_next;
    idx_t                 count_reg, count_next;
    sum_t                 sum_reg, sum_next;
    temp_t                max_reg, max_next, min_reg, min_next;
    idx_t                 max_at_reg, max_at_next, min_at_reg, min_at_next;
    logic                 pend_valid_reg;
    logic                 pend_from_ram_reg;
    logic                 pend_hit_reg;
    tls_job_t             pend_job_reg;
    tls_job_t             job;

    logic                 accept;
    logic                 is_sample;
    logic                 first;
    logic                 nmax, nmin;
    slot_t                ws, ws_inc;
    logic                 rd_in_range;
    logic                 hit;
    logic [AW-1:0]        raddr;
    logic [TEMP_W-1:0]    ram_rdata;
    sum_t                 sum_abs;

    assign req.ready = !pend_valid_reg;
    assign accept    = req.valid && req.ready;
    assign is_sample = (req.kind == KIND_SAMPLE);

    // Treat an out-of-range write slot as slot zero.
    assign ws     = (write_slot_reg >= SLOT_W'(LOG_DEPTH)) ? '0 : write_slot_reg;
    assign ws_inc = ws + SLOT_W'(1);
    assign first  = (count_reg == '0);
    assign nmax   = first || (req.temperature > max_reg);
    assign nmin   = first || (req.temperature < min_reg);

    assign rd_in_range = (req.read_slot < SLOT_W'(LOG_DEPTH));
    assign raddr       = req.read_slot[AW-1:0];
    assign hit         = rd_in_range ? valid_reg[raddr] : 1'b0;

    tls_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (LOG_DEPTH)
    ) u_log (
        .clk   (clk),
        .we    (accept && is_sample),
        .waddr (ws[AW-1:0]),
        .wdata (req.temperature),
        .re    (accept && !is_sample),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        write_slot_next = write_slot_reg;
        wrap_next       = wrap_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        max_next        = max_reg;
        min_next        = min_reg;
        max_at_next     = max_at_reg;
        min_at_next     = min_at_reg;
        if (accept && is_sample)
        begin
            if (nmax)
            begin
                max_next    = req.temperature;
                max_at_next = count_reg;
            end
            if (nmin)
            begin
                min_next    = req.temperature;
                min_at_next = count_reg;
            end
            // Freeze sum and count once the count saturates.
            if (count_reg != COUNT_MAX)
            begin
                sum_next   = sum_reg + SUM_W'(req.temperature);
                count_next = count_reg + IDX_W'(1);
            end
            if (ws_inc >= SLOT_W'(LOG_DEPTH))
            begin
                write_slot_next = '0;
                wrap_next       = wrap_reg + WRAP_W'(1);
            end
            else
            begin
                write_slot_next = ws_inc;
            end
        end
    end

    always_comb
    begin
        sum_abs          = (sum_next < 0) ? -sum_next : sum_next;
        job.slot         = is_sample ? ws : req.read_slot;
        job.wrap_total   = wrap_next;
        job.sample_index = is_sample ? count_reg : '0;
        job.max_temp     = max_next;
        job.max_index    = max_at_next;
        job.min_temp     = min_next;
        job.min_index    = min_at_next;
        job.new_max      = is_sample && nmax;
        job.new_min      = is_sample && nmin;
        job.log_value    = req.temperature;
        job.mean_neg     = (sum_next < 0);
        job.mean_mag     = sum_abs[MAG_W-1:0];
        job.mean_count   = count_next;
    end

    always_comb
    begin
        push_job = pend_job_reg;
        if (pend_from_ram_reg)
        begin
            push_job.log_value = pend_hit_reg ? temp_t'(ram_rdata) : '0;
        end
    end

    assign push = pend_valid_reg && !q_status.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            wrap_reg       <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
            max_reg        <= '0;
            min_reg        <= '0;
            max_at_reg     <= '0;
            min_at_reg     <= '0;
            pend_valid_reg <= 1'b0;
            for (int i = 0; i < LOG_DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            write_slot_reg <= write_slot_next;
            wrap_reg       <= wrap_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            max_reg        <= max_next;
            min_reg        <= min_next;
            max_at_reg     <= max_at_next;
            min_at_reg     <= min_at_next;
            if (accept)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (push)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (accept && is_sample)
            begin
                valid_reg[ws[AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_job_reg      <= job;
            pend_from_ram_reg <= !is_sample;
            pend_hit_reg      <= hit;
        end
    end
endmodule

### src/tls_queue.sv
// Two-entry job queue between the front end and the divider.
`timescale 1ns / 1ps
module tls_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  tls_pkg::tls_job_t       push_job,
    input  logic                    pop,
    output tls_pkg::tls_job_t       head,
    output tls_pkg::tls_q_status_t  status
);
    import tls_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    tls_job_t        entry_reg [Q_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     fill_reg;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (fill_reg == (PW+1)'(Q_DEPTH));
    assign status.empty = (fill_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + (PW+1)'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end
endmodule

### src/tls_back.sv
// Back end: serial divider for the running mean and the result register.
`timescale 1ns / 1ps
module tls_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tls_pkg::tls_q_status_t q_status,
    input  tls_pkg::tls_job_t      head,
    output logic                   pop,
    tls_rsp_if.source              rsp
);
    import tls_pkg::*;

    tls_back_state_t state_reg, state_next;
    tls_job_t        job_reg, job_next;
    logic [IDX_W-1:0] rem_reg, rem_next;
    mag_t            dvd_reg, dvd_next;
    mag_t            quo_reg, quo_next;
    step_t           step_reg, step_next;
    logic [7:0]      whole_reg, whole_next;
    logic            out_valid_reg, out_valid_next;
    tls_result_t     out_reg, out_next;

    logic [IDX_W:0]  trial;
    logic            ge;
    logic [IDX_W-1:0] rem_step;
    mag_t            prod;
    logic            out_free;
    logic            dividing;
    logic [7:0]      whole_signed;

    // One restoring division step: shift in a dividend bit, subtract if it fits.
    assign trial    = {rem_reg, dvd_reg[MAG_W-1]};
    assign ge       = (trial >= {1'b0, job_reg.mean_count});
    assign rem_step = ge ? IDX_W'(trial - {1'b0, job_reg.mean_count}) : trial[IDX_W-1:0];
    assign prod     = MAG_W'(rem_reg) * MAG_W'(HUNDRED);
    assign out_free = !out_valid_reg || rsp.ready;
    assign dividing = (state_reg == BK_DIV1) || (state_reg == BK_DIV2);
    assign pop      = (state_reg == BK_IDLE) && !q_status.empty;
    assign whole_signed = job_reg.mean_neg ? -whole_reg : whole_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = (head.mean_count == '0) ? BK_DONE : BK_DIV1;
                end
            end
            BK_DIV1:
            begin
                if (step_reg == step_t'(1))
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                state_next = BK_DIV2;
            end
            BK_DIV2:
            begin
                if (step_reg == step_t'(1))
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        job_next       = job_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        whole_next     = whole_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        if (dividing)
        begin
            rem_next  = rem_step;
            dvd_next  = {dvd_reg[MAG_W-2:0], 1'b0};
            quo_next  = {quo_reg[MAG_W-2:0], ge};
            step_next = step_reg - step_t'(1);
        end
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    job_next   = head;
                    rem_next   = '0;
                    dvd_next   = head.mean_mag;
                    quo_next   = '0;
                    whole_next = '0;
                    step_next  = step_t'(MAG_W);
                end
            end
            BK_DIV1:
            begin
                if (step_reg == step_t'(1))
                begin
                    whole_next = quo_next[7:0];
                end
            end
            BK_MUL:
            begin
                // Remainder times 100 over the count is below 100, so only
                // the low seven dividend bits still need a step each.
                rem_next  = prod[MAG_W-1:FRAC_STEPS];
                dvd_next  = {prod[FRAC_STEPS-1:0], (MAG_W-FRAC_STEPS)'(0)};
                quo_next  = '0;
                step_next = step_t'(FRAC_STEPS);
            end
            BK_DIV2:
            begin
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.slot           = job_reg.slot;
                    out_next.wrap_total     = job_reg.wrap_total;
                    out_next.sample_index   = job_reg.sample_index;
                    out_next.mean_whole     = temp_t'(whole_signed);
                    out_next.mean_hundredths = quo_reg[HUND_W-1:0];
                    out_next.max_temp       = job_reg.max_temp;
                    out_next.max_index      = job_reg.max_index;
                    out_next.min_temp       = job_reg.min_temp;
                    out_next.min_index      = job_reg.min_index;
                    out_next.new_max        = job_reg.new_max;
                    out_next.new_min        = job_reg.new_min;
                    out_next.log_value      = job_reg.log_value;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        quo_reg   <= quo_next;
        whole_reg <= whole_next;
        out_reg   <= out_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.slot            = out_reg.slot;
    assign rsp.wrap_total      = out_reg.wrap_total;
    assign rsp.sample_index    = out_reg.sample_index;
    assign rsp.mean_whole      = out_reg.mean_whole;
    assign rsp.mean_hundredths = out_reg.mean_hundredths;
    assign rsp.max_temp        = out_reg.max_temp;
    assign rsp.max_index       = out_reg.max_index;
    assign rsp.min_temp        = out_reg.min_temp;
    assign rsp.min_index       = out_reg.min_index;
    assign rsp.new_max         = out_reg.new_max;
    assign rsp.new_min         = out_reg.new_min;
    assign rsp.log_value       = out_reg.log_value;
endmodule

### src/temperature_log_statistics.sv
// Top level: temperature ring log with running mean, maximum and minimum.
`timescale 1ns / 1ps
// Each request either records a signed temperature sample into a ring log of
// LOG_DEPTH slots or reads one slot back, and every request yields exactly one
// result transfer carrying the ring wrap count, the running mean (whole part
// truncated toward zero plus hundredths of its magnitude), and the maximum and
// minimum with the sample index at which each occurred. The log reads as zero
// in every slot after reset: per-slot valid bits are cleared at once, so no
// clearing pass is needed and requests are taken straight out of reset. The
// front end takes a request, updates the statistics and reads the log,
// registers the job and hands it over a two-entry queue to the back end. The
// back end computes the mean with a one-bit-per-cycle restoring divider: 23
// steps for the whole part, a step that scales the remainder by 100, and 7
// steps for the hundredths; the division is skipped when no sample has been
// counted yet. The back end takes the next job only once its result is in the
// result register; the queue and the result register let the front end keep
// accepting while the back end is busy or a result waits. The sample count
// saturates at 65535, after which the mean is held but samples are still
// logged and still compete for maximum and minimum.
module temperature_log_statistics #(
    parameter int LOG_DEPTH = 99
) (
    input  logic       clk,
    input  logic       rst_n,
    tls_req_if.sink    req,
    tls_rsp_if.source  rsp
);
    import tls_pkg::*;

    // Front end to queue
    logic          push;
    tls_job_t      push_job;
    // Queue to back end
    logic          pop;
    tls_job_t      head;
    tls_q_status_t q_status;

    // Classify the request, update the log and the statistics.
    tls_front #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    // Hold jobs so the front end and the divider stall independently.
    tls_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    // Divide the running sum by the count and drive the result transfer.
    tls_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head     (head),
        .pop      (pop),
        .rsp      (rsp)
    );
endmodule
